// ===== hdl/ssrg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssrg_pkg
// Types and constants shared by the stick-slip ramp generator modules.
// ----------------------------------------------------------------------------
package ssrg_pkg;

    localparam int unsigned RAIL_OFFSET_INT = 12000;
    localparam logic [16:0] RAIL_OFFSET     = 17'd12000;
    localparam logic [19:0] US_PER_SECOND   = 20'd1000000;
    localparam logic [7:0]  BROADCAST_REG   = 8'h06;

    localparam int unsigned FREQ_W   = 17;
    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned REMAIN_W = 27;
    localparam int unsigned SQ_W     = 40;
    localparam int unsigned NUM_W    = 56;
    localparam int unsigned CNT_W    = 5;
    localparam logic [16:0] FREQ_RESET = 17'd1000;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    localparam int unsigned ADDR_W  = 3;
    localparam logic        REG_FREQ = 1'b0;

    localparam logic [CNT_W-1:0] DIV_STEPS_PERIOD = 5'd20;
    localparam logic [CNT_W-1:0] DIV_STEPS_RAMP   = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PDIV,
        ST_SQT,
        ST_SQP,
        ST_MLO,
        ST_MHI,
        ST_VDIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_ctl;

endpackage
`default_nettype wire

// ===== hdl/ssrg_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssrg_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssrg_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssrg_pkg::t_div_ctl i_ctl,
    input  wire logic [39:0]       i_rem,
    input  wire logic [19:0]       i_dvd,
    input  wire logic [39:0]       i_den,
    output logic [19:0]            o_quo,
    output logic                   o_done
);

    logic                       r_busy;
    logic                       r_done;
    logic [ssrg_pkg::CNT_W-1:0] r_cnt;
    logic [39:0]                r_rem;
    logic [19:0]                r_dvd;
    logic [39:0]                r_den;
    logic [19:0]                r_quo;

    logic [40:0] shifted;
    logic        fits;
    logic [40:0] diff;

    assign shifted = {r_rem, r_dvd[19]};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_dvd <= i_dvd;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[39:0] : shifted[39:0];
            r_dvd <= {r_dvd[18:0], 1'b0};
            r_quo <= {r_quo[18:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hdl/stick_slip_ramp_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stick_slip_ramp_generator
// Piezo stick-slip drive waveform generator with quadratic ramps.
// ----------------------------------------------------------------------------
// One request at a time: s_axis_tready is high only while the sequencer is
// idle. Abort, idle ticks, other ignored requests and the floor frame at the end
// of a period go straight to the output stage; a started run first waits for
// the 20-step period divider; a ramp tick makes four passes through the shared
// 20x20 multiplier (t^2, period^2, span times both halves of t^2) and a 16-step
// divide. A finished result waits in the output register while the next
// request is taken.
module stick_slip_ramp_generator #(
    parameter int unsigned DAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // direction, run_seconds[6:0]
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // dac_value[15:0], dac_frame[23:0]
    output logic [3:0]       m_axis_tuser   // frame_valid, is_running, run_done, abort_ack
);

    localparam int unsigned FULL_SCALE = (1 << DAC_BITS) - 1;
    localparam int unsigned SPAN_INT   = (FULL_SCALE > ssrg_pkg::RAIL_OFFSET_INT)
                                         ? FULL_SCALE - ssrg_pkg::RAIL_OFFSET_INT : 0;
    localparam logic [15:0] SPAN       = 16'(SPAN_INT);
    localparam logic [16:0] FS         = 17'(FULL_SCALE);

    ssrg_pkg::t_state r_state, n_state;

    logic        r_active, n_active;
    logic        r_ramp_up, n_ramp_up;
    logic [19:0] r_period, n_period;
    logic [19:0] r_phase, n_phase;
    logic [26:0] r_remaining, n_remaining;
    logic [16:0] r_freq;
    logic [39:0] r_sq, n_sq;
    logic [39:0] r_psq, n_psq;
    logic [39:0] r_prod, n_prod;
    logic [15:0] r_level, n_level;
    logic        r_fvalid, n_fvalid;
    logic        r_done, n_done;
    logic        r_ack, n_ack;
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;
    logic [3:0]  r_out_user, n_out_user;

    logic [19:0] mul_a, mul_b;
    logic [39:0] mul_p;
    logic [55:0] num;

    ssrg_pkg::t_div_ctl div_ctl;
    logic [39:0]        div_rem;
    logic [19:0]        div_dvd;
    logic [39:0]        div_den;
    logic [19:0]        div_quo;
    logic               div_done;

    logic        req_take;
    logic [1:0]  req_cmd;
    logic        req_dir;
    logic [6:0]  req_secs;
    logic [20:0] tick_t;
    logic [26:0] rem_dec;
    logic [16:0] code_sum;
    logic [15:0] code;
    logic        cfg_write;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ssrg_pkg::REG_FREQ);
    assign prdata    = (paddr[2] == ssrg_pkg::REG_FREQ) ? {15'd0, r_freq} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= ssrg_pkg::FREQ_RESET;
        end else if (cfg_write && !r_active) begin
            r_freq <= pwdata[16:0];
        end
    end

    assign s_axis_tready = (r_state == ssrg_pkg::ST_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign req_cmd       = s_axis_tuser;
    assign req_dir       = s_axis_tdata[0];
    assign req_secs      = s_axis_tdata[7:1];

    assign mul_p   = mul_a * mul_b;
    assign num     = 56'(r_prod) + {mul_p[35:0], 20'd0};
    assign tick_t  = {1'b0, r_phase} + 21'd1;
    assign rem_dec = (r_remaining != 0) ? r_remaining - 1'b1 : r_remaining;

    assign code_sum = {1'b0, r_level} + ssrg_pkg::RAIL_OFFSET;
    assign code     = (code_sum > FS) ? FS[15:0] : code_sum[15:0];

    ssrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssrg_pkg::ST_IDLE;
            r_active    <= 1'b0;
            r_ramp_up   <= 1'b0;
            r_period    <= '0;
            r_phase     <= '0;
            r_remaining <= '0;
            r_fvalid    <= 1'b0;
            r_done      <= 1'b0;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_ramp_up   <= n_ramp_up;
            r_period    <= n_period;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_fvalid    <= n_fvalid;
            r_done      <= n_done;
            r_ack       <= n_ack;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq       <= n_sq;
        r_psq      <= n_psq;
        r_prod     <= n_prod;
        r_level    <= n_level;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_ramp_up   = r_ramp_up;
        n_period    = r_period;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_sq        = r_sq;
        n_psq       = r_psq;
        n_prod      = r_prod;
        n_level     = r_level;
        n_fvalid    = r_fvalid;
        n_done      = r_done;
        n_ack       = r_ack;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mul_a       = '0;
        mul_b       = '0;
        div_ctl     = '{start: 1'b0, steps: ssrg_pkg::DIV_STEPS_RAMP};
        div_rem     = '0;
        div_dvd     = '0;
        div_den     = '0;

        case (r_state)
            ssrg_pkg::ST_IDLE: begin
                if (req_take) begin
                    n_fvalid = 1'b0;
                    n_done   = 1'b0;
                    n_ack    = 1'b0;
                    n_level  = '0;
                    n_state  = ssrg_pkg::ST_FIN;
                    if (req_cmd == ssrg_pkg::CMD_ABORT) begin
                        n_active = 1'b0;
                        n_phase  = '0;
                        n_ack    = 1'b1;
                    end else if (req_cmd == ssrg_pkg::CMD_START) begin
                        if (!r_active) begin
                            if (req_secs == 0) begin
                                n_done = 1'b1;
                            end else begin
                                // run length and period division
                                mul_a       = {13'd0, req_secs};
                                mul_b       = ssrg_pkg::US_PER_SECOND;
                                n_remaining = mul_p[26:0];
                                div_ctl     = '{start: 1'b1,
                                                steps: ssrg_pkg::DIV_STEPS_PERIOD};
                                div_dvd     = ssrg_pkg::US_PER_SECOND;
                                div_den     = (r_freq == 0) ? 40'd1 : 40'(r_freq);
                                n_ramp_up   = req_dir;
                                n_phase     = '0;
                                n_active    = 1'b1;
                                n_fvalid    = 1'b1;
                                n_level     = req_dir ? 16'd0 : SPAN;
                                n_state     = ssrg_pkg::ST_PDIV;
                            end
                        end
                    end else if (req_cmd == ssrg_pkg::CMD_TICK && r_active) begin
                        n_remaining = rem_dec;
                        n_fvalid    = 1'b1;
                        if (tick_t > {1'b0, r_period}) begin
                            // floor frame, end of period
                            n_phase = '0;
                            if (rem_dec == 0) begin
                                n_active = 1'b0;
                                n_done   = 1'b1;
                            end
                        end else begin
                            n_phase = tick_t[19:0];
                            n_state = ssrg_pkg::ST_SQT;
                        end
                    end
                end
            end
            ssrg_pkg::ST_PDIV: begin
                if (div_done) begin
                    n_period = (div_quo == 0) ? 20'd1 : div_quo;
                    n_state  = ssrg_pkg::ST_FIN;
                end
            end
            ssrg_pkg::ST_SQT: begin
                mul_a   = r_phase;
                mul_b   = r_phase;
                n_sq    = mul_p;
                n_state = ssrg_pkg::ST_SQP;
            end
            ssrg_pkg::ST_SQP: begin
                mul_a   = r_period;
                mul_b   = r_period;
                n_psq   = mul_p;
                n_state = ssrg_pkg::ST_MLO;
            end
            ssrg_pkg::ST_MLO: begin
                mul_a   = {4'd0, SPAN};
                mul_b   = r_sq[19:0];
                n_prod  = mul_p;
                n_state = ssrg_pkg::ST_MHI;
            end
            ssrg_pkg::ST_MHI: begin
                mul_a   = {4'd0, SPAN};
                mul_b   = r_sq[39:20];
                div_ctl = '{start: 1'b1, steps: ssrg_pkg::DIV_STEPS_RAMP};
                div_rem = num[55:16];
                div_dvd = {num[15:0], 4'd0};
                div_den = r_psq;
                n_state = ssrg_pkg::ST_VDIV;
            end
            ssrg_pkg::ST_VDIV: begin
                if (div_done) begin
                    n_level = r_ramp_up ? div_quo[15:0] : SPAN - div_quo[15:0];
                    n_state = ssrg_pkg::ST_FIN;
                end
            end
            ssrg_pkg::ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_fvalid ? {ssrg_pkg::BROADCAST_REG, code, code}
                                           : 40'd0;
                    n_out_user  = {r_ack, r_done, r_active, r_fvalid};
                    n_state     = ssrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssrg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire

// ===== bench/tb_stick_slip_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// tb_stick_slip_ramp_generator
// Self-checking bench for the stick-slip ramp generator. Requests go in on the
// slave stream and every result is compared field by field with a cycle-free
// model of the ramp sequencer (quadratic ramps, floor frames, aborts, ignored
// starts). The drive frequency is set over apb between request bursts and read
// back. Directed runs cover the corner cases; random traffic then runs under
// several source and sink throttling mixes, plus a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_stick_slip_ramp_generator;

    localparam int unsigned DAC_BITS     = 16;
    localparam int unsigned FULL_SCALE   = (1 << DAC_BITS) - 1;
    localparam int unsigned RAMP_SPAN    =
        (FULL_SCALE > ssrg_pkg::RAIL_OFFSET_INT)
        ? FULL_SCALE - ssrg_pkg::RAIL_OFFSET_INT : 0;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [2:0]  FREQ_ADDR    = 3'd0;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MAX_GAP      = 200;
    localparam int          RANDOM_QUOTA = 225;

    typedef struct packed {
        logic [15:0] dac_value;
        logic [23:0] dac_frame;
        logic        frame_valid;
        logic        is_running;
        logic        run_done;
        logic        abort_ack;
    } t_waveform;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    // model state
    logic [16:0] drive_freq;
    logic        run_active;
    logic        rising;
    logic [19:0] period_ticks;
    logic [19:0] phase_ticks;
    logic [26:0] remaining_ticks;

    t_waveform pending_waveforms[$];
    t_waveform oldest_waveform;
    int        mismatch_count;
    int        requests_sent;
    int        tx_idle_pct;
    int        rx_stall_pct;
    int        sink_hold_cycles;

    stick_slip_ramp_generator #(
        .DAC_BITS(DAC_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_waveform make_waveform(input logic valid, input int unsigned level,
                                                input logic done, input logic ack);
        t_waveform w;
        int unsigned code;
        code = 0;
        if (valid) begin
            code = level + ssrg_pkg::RAIL_OFFSET_INT;
            if (code > FULL_SCALE)
                code = FULL_SCALE;
        end
        w.dac_value   = code[15:0];
        w.dac_frame   = valid ? {ssrg_pkg::BROADCAST_REG, code[15:0]} : 24'd0;
        w.frame_valid = valid;
        w.is_running  = run_active;
        w.run_done    = done;
        w.abort_ack   = ack;
        return w;
    endfunction

    function automatic t_waveform predict_waveform(input logic [1:0] cmd, input logic dir,
                                                   input logic [6:0] secs);
        int unsigned freq;
        int unsigned t;
        bit [63:0]   num;
        bit [63:0]   den;
        int unsigned level;
        logic        done;
        if (cmd == ssrg_pkg::CMD_ABORT) begin
            run_active  = 1'b0;
            phase_ticks = '0;
            return make_waveform(1'b0, 0, 1'b0, 1'b1);
        end
        if (cmd == ssrg_pkg::CMD_START) begin
            if (run_active)
                return make_waveform(1'b0, 0, 1'b0, 1'b0);
            if (secs == 0)
                return make_waveform(1'b0, 0, 1'b1, 1'b0);
            freq = (drive_freq == 0) ? 1 : drive_freq;
            period_ticks = 20'(1000000 / freq);
            if (period_ticks == 0)
                period_ticks = 20'd1;
            rising          = dir;
            phase_ticks     = '0;
            remaining_ticks = 27'(secs * 1000000);
            run_active      = 1'b1;
            return make_waveform(1'b1, rising ? 0 : RAMP_SPAN, 1'b0, 1'b0);
        end
        if (cmd == ssrg_pkg::CMD_TICK && run_active) begin
            t = phase_ticks + 1;
            if (remaining_ticks > 0)
                remaining_ticks = remaining_ticks - 1;
            if (t > period_ticks) begin
                done        = 1'b0;
                phase_ticks = '0;
                if (remaining_ticks == 0) begin
                    run_active = 1'b0;
                    done       = 1'b1;
                end
                return make_waveform(1'b1, 0, done, 1'b0);
            end
            num   = 64'(RAMP_SPAN) * 64'(t) * 64'(t);
            den   = 64'(period_ticks) * 64'(period_ticks);
            level = int'(num / den);
            phase_ticks = t[19:0];
            return make_waveform(1'b1, rising ? level : RAMP_SPAN - level, 1'b0, 1'b0);
        end
        return make_waveform(1'b0, 0, 1'b0, 1'b0);
    endfunction

    function automatic void check_field(input string name, input logic [39:0] want,
                                        input logic [39:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_waveforms.size() == 0) begin
                $display("%0t unexpected result: expected none actual %0h/%0h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                oldest_waveform = pending_waveforms.pop_front();
                check_field("dac_value", 40'(oldest_waveform.dac_value), 40'(m_axis_tdata[15:0]));
                check_field("dac_frame", 40'(oldest_waveform.dac_frame),
                            40'(m_axis_tdata[39:16]));
                check_field("frame_valid", 40'(oldest_waveform.frame_valid),
                            40'(m_axis_tuser[0]));
                check_field("is_running", 40'(oldest_waveform.is_running), 40'(m_axis_tuser[1]));
                check_field("run_done", 40'(oldest_waveform.run_done), 40'(m_axis_tuser[2]));
                check_field("abort_ack", 40'(oldest_waveform.abort_ack), 40'(m_axis_tuser[3]));
            end
        end
    end

    // sink throttling, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            sink_hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic dir, input logic [6:0] secs);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {secs, dir};
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!(cmd == CMD_UNUSED || (cmd == ssrg_pkg::CMD_TICK && !run_active)))
            requests_sent++;
        pending_waveforms.push_back(predict_waveform(cmd, dir, secs));
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(ssrg_pkg::CMD_TICK, 1'($urandom_range(1)), 7'($urandom_range(127)));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending_waveforms.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the frequency register, then read it back
    task automatic write_drive_frequency(input logic [31:0] value);
        wait_results_drained();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = FREQ_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!run_active)
            drive_freq = value[16:0];
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("drive_frequency_hz", 40'(drive_freq), 40'(prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [31:0] pick_frequency();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 32'($urandom_range(20000, 131071));
        if (pick < 90)
            return 32'($urandom_range(1000, 19999));
        return 32'($urandom_range(131071));
    endfunction

    task automatic test_idle_commands();
        send_request(ssrg_pkg::CMD_TICK, 1'b1, 7'd127);
        send_request(CMD_UNUSED, 1'b1, 7'd127);
        send_request(ssrg_pkg::CMD_ABORT, 1'b0, 7'd0);
    endtask

    task automatic test_zero_length_run();
        send_request(ssrg_pkg::CMD_START, 1'b1, 7'd0);
    endtask

    task automatic test_rising_run();
        send_request(ssrg_pkg::CMD_START, 1'b1, 7'd1);
        send_ticks(3);
        send_request(ssrg_pkg::CMD_START, 1'b0, 7'd5);
        send_request(ssrg_pkg::CMD_ABORT, 1'b1, 7'd127);
    endtask

    task automatic test_short_period_falling();
        write_drive_frequency(32'd131071);
        send_request(ssrg_pkg::CMD_START, 1'b0, 7'd127);
        send_ticks(9);
        send_request(ssrg_pkg::CMD_ABORT, 1'b0, 7'd0);
    endtask

    task automatic test_frequency_extremes();
        write_drive_frequency(32'd0);
        send_request(ssrg_pkg::CMD_START, 1'b1, 7'd99);
        send_ticks(1);
        // frequency must hold while a run is active
        write_drive_frequency(32'd99999);
        send_request(ssrg_pkg::CMD_ABORT, 1'b0, 7'd0);
        write_drive_frequency(32'hFFFE_0001);
        write_drive_frequency(32'd99999);
    endtask

    task automatic test_sink_hold_off();
        wait_results_drained();
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        sink_hold_cycles = 400;
        send_request(ssrg_pkg::CMD_START, 1'($urandom_range(1)), 7'($urandom_range(1, 127)));
        send_ticks(40);
        send_request(ssrg_pkg::CMD_ABORT, 1'b0, 7'd0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int src_idle, input int sink_stall, input int quota);
        int first;
        int since_write;
        int pick;
        tx_idle_pct  = src_idle;
        rx_stall_pct = sink_stall;
        first        = requests_sent;
        since_write  = 0;
        write_drive_frequency(pick_frequency());
        while (requests_sent - first < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_request(ssrg_pkg::CMD_START, 1'($urandom_range(1)),
                             7'($urandom_range(1, 127)));
                if ($urandom_range(9) == 0)
                    write_drive_frequency(pick_frequency());
                repeat ($urandom_range(1, 80)) begin
                    if ($urandom_range(99) < 5)
                        send_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                                     7'($urandom_range(127)));
                    else
                        send_ticks(1);
                end
                send_request(ssrg_pkg::CMD_ABORT, 1'($urandom_range(1)),
                             7'($urandom_range(127)));
            end else begin
                send_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                             7'($urandom_range(127)));
            end
            since_write++;
            if (since_write > 4 && $urandom_range(3) == 0) begin
                write_drive_frequency(pick_frequency());
                since_write = 0;
            end
        end
        wait_results_drained();
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = FREQ_ADDR;
        pwdata           = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = ssrg_pkg::CMD_TICK;
        m_axis_tready    = 1'b0;
        mismatch_count   = 0;
        requests_sent    = 0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        sink_hold_cycles = 0;
        drive_freq       = ssrg_pkg::FREQ_RESET;
        run_active       = 1'b0;
        rising           = 1'b0;
        period_ticks     = '0;
        phase_ticks      = '0;
        remaining_ticks  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_commands();
        test_zero_length_run();
        test_rising_run();
        test_short_period_falling();
        test_frequency_extremes();
        test_random_traffic(0, 0, RANDOM_QUOTA);
        test_sink_hold_off();
        test_random_traffic(86, 0, RANDOM_QUOTA);
        test_random_traffic(0, 86, RANDOM_QUOTA);
        test_random_traffic(25, 25, RANDOM_QUOTA);

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
